>>> rtl/core/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared widths, register map, microcode encoding and control store for the
// scalar Kalman smoother.
// ----------------------------------------------------------------------------
package ksm_pkg;

    // field and datapath widths
    localparam int SampleW = 40;           // Q23.16 sample and estimate
    localparam int DiffW   = SampleW + 1;  // sample - estimate
    localparam int CovW    = 32;           // Q0.32 covariance and noise
    localparam int GainW   = 32;           // Q0.32 gain
    localparam int DenomW  = CovW + 1;     // prior + measure noise
    localparam int MulBW   = 33;           // multiplier signed operand
    localparam int ProdW   = GainW + MulBW; // kept product bits
    localparam int AccW    = 73;           // full gain * diff product
    localparam int DlW     = 16;           // low split of the difference
    localparam int PcW     = 3;
    localparam int DivCntW = 5;
    localparam int AddrW   = 3;
    localparam int DataW   = 32;

    localparam logic [DivCntW-1:0] DivLast = DivCntW'(GainW - 1);

    // register reset values
    localparam logic [CovW-1:0] ProcessNoiseRst = 32'd429497;
    localparam logic [CovW-1:0] MeasureNoiseRst = 32'd21474836;

    // register index, decoded from paddr[2]
    typedef enum logic {
        REG_PROCESS_NOISE = 1'b0,
        REG_MEASURE_NOISE = 1'b1
    } reg_idx_t;

    // datapath operation of one step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_DH,
        OP_MUL_DL,
        OP_MUL_P,
        OP_EMIT
    } op_t;

    // jump condition of one step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_BEAT,
        COND_MN_ZERO,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PcW-1:0]  target;
    } uword_t;

    // program addresses
    localparam logic [PcW-1:0] PcWait  = 3'd0;
    localparam logic [PcW-1:0] PcInit  = 3'd1;
    localparam logic [PcW-1:0] PcDiv   = 3'd2;
    localparam logic [PcW-1:0] PcMulDh = 3'd3;
    localparam logic [PcW-1:0] PcMulDl = 3'd4;
    localparam logic [PcW-1:0] PcMulP  = 3'd5;
    localparam logic [PcW-1:0] PcEmit  = 3'd6;
    localparam logic [PcW-1:0] PcBack  = 3'd7;

    // control store: jump to target when the condition holds, else fall through
    function automatic uword_t ucode_rom(input logic [PcW-1:0] pc);
        uword_t uw;
        case (pc)
            PcWait:  uw = '{op: OP_WAIT,     cond: COND_NO_BEAT,  target: PcWait};
            PcInit:  uw = '{op: OP_DIV_INIT, cond: COND_MN_ZERO,  target: PcMulDh};
            PcDiv:   uw = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: PcDiv};
            PcMulDh: uw = '{op: OP_MUL_DH,   cond: COND_NEVER,    target: PcWait};
            PcMulDl: uw = '{op: OP_MUL_DL,   cond: COND_NEVER,    target: PcWait};
            PcMulP:  uw = '{op: OP_MUL_P,    cond: COND_NEVER,    target: PcWait};
            PcEmit:  uw = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: PcEmit};
            PcBack:  uw = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PcWait};
            default: uw = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PcWait};
        endcase
        return uw;
    endfunction

endpackage

>>> rtl/core/scalar_kalman_smoother_top.sv
// ----------------------------------------------------------------------------
// scalar_kalman_smoother_top
// Sequence: after an input beat the gain divider runs its 32 restoring steps
//   (skipped with zero measure noise), then the three shared multiplier
//   steps and the emit step raise m_valid. A new beat is taken only after
//   the previous one has been emitted; the divider yields one bit per cycle.
// Reset: synchronous active-low aresetn clears estimate and covariance,
//   restores the noise registers and drops m_valid.
// One-dimensional Kalman smoother run by a small microcoded sequencer over
// a divider, one multiplier and an accumulator.
// ----------------------------------------------------------------------------
module scalar_kalman_smoother_top import ksm_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // sample channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [SampleW-1:0] s_sample,
    // estimate channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [SampleW-1:0] m_estimate_out,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [AddrW-1:0]          paddr,
    input  logic [DataW-1:0]          pwdata,
    output logic [DataW-1:0]          prdata,
    output logic                      pready
);

    // sequencer
    logic [PcW-1:0]     pc_reg, pc_next;
    uword_t             uw;
    logic               cond_true;

    // configuration
    logic [CovW-1:0]    pn_reg, pn_next;
    logic [CovW-1:0]    mn_reg, mn_next;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    // filter state
    logic signed [SampleW-1:0] est_reg, est_next;
    logic [CovW-1:0]           cov_reg, cov_next;

    // working registers
    logic [CovW-1:0]           prior_reg, prior_next;
    logic signed [DiffW-1:0]   diff_reg, diff_next;
    logic [DenomW-1:0]         denom_reg, denom_next;
    logic [DenomW-1:0]         rem_reg, rem_next;
    logic [DivCntW-1:0]        cnt_reg, cnt_next;
    logic [GainW-1:0]          gain_reg, gain_next;
    logic signed [ProdW-1:0]   prod_reg, prod_next;
    logic signed [AccW-1:0]    acc_reg, acc_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    logic signed [SampleW-1:0] m_est_reg, m_est_next;

    // combinational helpers
    logic                      in_beat;
    logic                      out_busy;
    logic                      emit_fire;
    logic [CovW:0]             prior_sum;
    logic [DenomW:0]           div_shift;
    logic [DenomW:0]           div_trial;
    logic signed [MulBW-1:0]   mul_b;
    logic signed [ProdW:0]     mul_full;
    logic signed [DiffW-1:0]   est_sum;

    assign uw        = ucode_rom(pc_reg);
    assign s_ready   = (uw.op == OP_WAIT);
    assign in_beat   = s_valid && s_ready;
    assign out_busy  = m_valid_reg && !m_ready;
    assign emit_fire = (uw.op == OP_EMIT) && !out_busy;

    assign m_valid        = m_valid_reg;
    assign m_estimate_out = m_est_reg;

    // register port: always ready, decoded on the word address bit
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_PROCESS_NOISE: prdata = pn_reg;
            REG_MEASURE_NOISE: prdata = mn_reg;
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        pn_next = pn_reg;
        mn_next = mn_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_PROCESS_NOISE: pn_next = pwdata;
                REG_MEASURE_NOISE: mn_next = pwdata;
                default:           pn_next = pn_reg;
            endcase
        end
    end

    // jump condition and next step
    always_comb begin
        case (uw.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_BEAT:  cond_true = !s_valid;
            COND_MN_ZERO:  cond_true = (mn_reg == '0);
            COND_DIV_MORE: cond_true = (cnt_reg != DivLast);
            COND_OUT_BUSY: cond_true = out_busy;
            default:       cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uw.target : pc_reg + PcW'(1);
    end

    // saturating prior and divider trial subtract
    assign prior_sum = {1'b0, cov_reg} + {1'b0, pn_reg};
    assign div_shift = {rem_reg, 1'b0};
    assign div_trial = div_shift - {1'b0, denom_reg};

    // shared multiplier: gain times a selected signed operand
    always_comb begin
        case (uw.op)
            OP_MUL_DH: mul_b = {{(MulBW-(DiffW-DlW)){diff_reg[DiffW-1]}},
                                diff_reg[DiffW-1:DlW]};
            OP_MUL_DL: mul_b = {{(MulBW-DlW){1'b0}}, diff_reg[DlW-1:0]};
            default:   mul_b = {1'b0, prior_reg};
        endcase
    end
    assign mul_full = $signed({1'b0, gain_reg}) * mul_b;

    // estimate step: old estimate plus the floored gain*diff
    assign est_sum = {est_reg[SampleW-1], est_reg} + acc_reg[AccW-1:GainW];

    // datapath next values
    always_comb begin
        prior_next   = prior_reg;
        diff_next    = diff_reg;
        denom_next   = denom_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        gain_next    = gain_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        est_next     = est_reg;
        cov_next     = cov_reg;
        m_est_next   = m_est_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (uw.op)
            OP_WAIT: begin
                if (in_beat) begin
                    prior_next = prior_sum[CovW] ? '1 : prior_sum[CovW-1:0];
                    diff_next  = {s_sample[SampleW-1], s_sample}
                               - {est_reg[SampleW-1], est_reg};
                end
            end
            OP_DIV_INIT: begin
                rem_next   = {1'b0, prior_reg};
                denom_next = {1'b0, prior_reg} + {1'b0, mn_reg};
                cnt_next   = '0;
                // zero measure noise: gain is one (saturated) or zero
                if (mn_reg == '0) begin
                    gain_next = (prior_reg != '0) ? '1 : '0;
                end else begin
                    gain_next = '0;
                end
            end
            OP_DIV_STEP: begin
                cnt_next = cnt_reg + DivCntW'(1);
                if (!div_trial[DenomW]) begin
                    rem_next  = div_trial[DenomW-1:0];
                    gain_next = {gain_reg[GainW-2:0], 1'b1};
                end else begin
                    rem_next  = div_shift[DenomW-1:0];
                    gain_next = {gain_reg[GainW-2:0], 1'b0};
                end
            end
            OP_MUL_DH: begin
                prod_next = mul_full[ProdW-1:0];
            end
            OP_MUL_DL: begin
                // high partial product lands 16 bits up
                acc_next  = {prod_reg[AccW-DlW-1:0], {DlW{1'b0}}};
                prod_next = mul_full[ProdW-1:0];
            end
            OP_MUL_P: begin
                acc_next  = acc_reg + {{(AccW-ProdW){prod_reg[ProdW-1]}}, prod_reg};
                prod_next = mul_full[ProdW-1:0];
            end
            OP_EMIT: begin
                if (emit_fire) begin
                    est_next     = est_sum[SampleW-1:0];
                    cov_next     = prior_reg - prod_reg[2*CovW-1:CovW];
                    m_est_next   = est_sum[SampleW-1:0];
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PcWait;
            pn_reg      <= ProcessNoiseRst;
            mn_reg      <= MeasureNoiseRst;
            est_reg     <= '0;
            cov_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            pn_reg      <= pn_next;
            mn_reg      <= mn_next;
            est_reg     <= est_next;
            cov_reg     <= cov_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        prior_reg <= prior_next;
        diff_reg  <= diff_next;
        denom_reg <= denom_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        gain_reg  <= gain_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        m_est_reg <= m_est_next;
    end

endmodule

>>> rtl/core/ksm_checker.sv
// ----------------------------------------------------------------------------
// ksm_checker
// Port-level checks on the scalar Kalman smoother, bound to the top level.
// ----------------------------------------------------------------------------
module ksm_checker import ksm_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [SampleW-1:0] m_estimate_out,
    input logic                      pready
);

    // a stalled result beat holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_estimate_out))
        else $error("stalled result beat changed");

    // reset drops the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one sample at a time, and no early result after a sample beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 (!s_ready && !$rose(m_valid)))
        else $error("sample beat taken or result produced too early");

    // register port never stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind scalar_kalman_smoother_top ksm_checker u_ksm_checker (.*);
